// ===== hdl/swsb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// swsb_pkg
// Shared types and constants for the scanline window span builder.
// ============================================================================
package swsb_pkg;

    // Position and count width; covers lists of up to 16 segments plus margin.
    localparam int POS_W = 5;

    localparam int MAX_SEGMENTS_DEF = 8;

    localparam logic [7:0]       LINE_WIDTH    = 8'd240;
    localparam logic [7:0]       VISIBLE_LINES = 8'd160;
    localparam logic [7:0]       NO_WIN_CTL    = 8'hFF;
    localparam logic [POS_W-1:0] RESULT_LIMIT  = POS_W'(8);

    // Up to four pieces per line: window 1 (two pieces) then window 0 (two).
    localparam logic [2:0] PIECES_DONE = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN0_H   = 3'd0,
        CFG_WIN1_H   = 3'd1,
        CFG_WIN0_V   = 3'd2,
        CFG_WIN1_V   = 3'd3,
        CFG_INSIDE   = 3'd4,
        CFG_OUTSIDE  = 3'd5,
        CFG_ENABLES  = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INIT,
        CELL_SPLIT,
        CELL_WRITE,
        CELL_OPEN,
        CELL_TRIM,
        CELL_SHIFT
    } t_cell_op;

    // Broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] top;
        logic [POS_W-1:0] count;
        logic [7:0]       lo_end;   // piece start column
        logic [7:0]       hi_end;   // piece end column, or restored end on open
        logic [7:0]       ctl;
    } t_cell_cmd;

    // Per-cell status back to the sequencer.
    typedef struct packed {
        logic first;   // first valid entry with start < seg_end
        logic split;   // start lies past this entry's left edge
        logic ge;      // piece end >= seg_end
    } t_cell_stat;

    typedef struct packed {
        logic       valid;
        logic [7:0] start;
        logic [7:0] seg_end;
        logic [7:0] ctl;
    } t_piece;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PREP,
        ST_FIND,
        ST_SPLIT,
        ST_WRITE,
        ST_TRIM,
        ST_OPEN,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/swsb_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// swsb_cell
// One entry of the segment row: end column and control, neighbor moves.
// ============================================================================
module swsb_cell #(
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  swsb_pkg::t_cell_cmd   i_cmd,
    input  logic [7:0]            i_prev_end,
    input  logic [7:0]            i_prev_ctl,
    input  logic [7:0]            i_next_end,
    input  logic [7:0]            i_next_ctl,
    input  logic                  i_seen,
    output logic [7:0]            o_end,
    output logic [7:0]            o_ctl,
    output logic                  o_seen,
    output swsb_pkg::t_cell_stat  o_stat
);
    import swsb_pkg::*;

    localparam logic [POS_W-1:0] IDX_V = POS_W'(IDX);

    logic [7:0]       r_end, n_end;
    logic [7:0]       r_ctl, n_ctl;
    logic [POS_W-1:0] pos1;
    logic             at_pos, at_pos1, above_pos, above_pos1, le_top;
    logic             valid, hit;

    assign pos1       = i_cmd.pos + POS_W'(1);
    assign at_pos     = (IDX_V == i_cmd.pos);
    assign at_pos1    = (IDX_V == pos1);
    assign above_pos  = (IDX_V > i_cmd.pos);
    assign above_pos1 = (IDX_V > pos1);
    assign le_top     = (IDX_V <= i_cmd.top);

    assign valid = (IDX_V < i_cmd.count);
    assign hit   = valid && (i_cmd.lo_end < r_end);

    assign o_stat.first = hit && !i_seen;
    assign o_stat.split = (i_cmd.lo_end > i_prev_end);
    assign o_stat.ge    = (i_cmd.hi_end >= r_end);
    assign o_seen       = i_seen | hit;
    assign o_end        = r_end;
    assign o_ctl        = r_ctl;

    always_comb begin
        n_end = r_end;
        n_ctl = r_ctl;
        case (i_cmd.op)
            CELL_INIT: begin
                if (IDX_V == '0) begin
                    n_end = LINE_WIDTH;
                    n_ctl = i_cmd.ctl;
                end
            end
            CELL_SPLIT: begin
                // Left part keeps its control, piece goes right after it.
                if (at_pos) begin
                    n_end = i_cmd.lo_end;
                end else if (at_pos1) begin
                    n_end = i_cmd.hi_end;
                    n_ctl = i_cmd.ctl;
                end else if (above_pos1 && le_top) begin
                    n_end = i_prev_end;
                    n_ctl = i_prev_ctl;
                end
            end
            CELL_WRITE: begin
                if (at_pos) begin
                    n_end = i_cmd.hi_end;
                    n_ctl = i_cmd.ctl;
                end
            end
            CELL_OPEN: begin
                if (at_pos) begin
                    n_end = i_cmd.hi_end;
                    n_ctl = i_cmd.ctl;
                end else if (above_pos && le_top) begin
                    n_end = i_prev_end;
                    n_ctl = i_prev_ctl;
                end
            end
            CELL_TRIM: begin
                if (at_pos) begin
                    n_end = i_next_end;
                    n_ctl = i_next_ctl;
                end
            end
            CELL_SHIFT: begin
                n_end = i_next_end;
                n_ctl = i_next_ctl;
            end
            default: begin
                n_end = r_end;
                n_ctl = r_ctl;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_end <= n_end;
        r_ctl <= n_ctl;
    end

endmodule
`default_nettype wire

// ===== hdl/swsb_piece_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// swsb_piece_gen
// Clamps a window's registers and yields one horizontal piece to place.
// ============================================================================
module swsb_piece_gen (
    input  logic [15:0]       i_win0_h,
    input  logic [15:0]       i_win1_h,
    input  logic [15:0]       i_win0_v,
    input  logic [15:0]       i_win1_v,
    input  logic [15:0]       i_inside,
    input  logic [1:0]        i_enables,
    input  logic [7:0]        i_line,
    input  logic [1:0]        i_piece,
    output swsb_pkg::t_piece  o_piece
);
    import swsb_pkg::*;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
    } t_range;

    function automatic t_range clamp_range(input logic [15:0] reg_v,
                                           input logic [7:0]  limit);
        t_range r;
        r.hi = reg_v[7:0];
        r.lo = reg_v[15:8];
        if (r.lo > limit && r.lo > r.hi) begin
            r.lo = 8'd0;
        end
        if (r.hi > limit) begin
            r.hi = limit;
            if (r.lo > limit) begin
                r.lo = limit;
            end
        end
        return r;
    endfunction

    logic        sel_w0;
    logic [15:0] h_reg, v_reg;
    logic [7:0]  ctl;
    logic        en;
    t_range      hr, vr;
    logic        v_active, wrap, has;
    logic [7:0]  start, seg_end;

    // Pieces 0/1 belong to window 1, pieces 2/3 to window 0.
    assign sel_w0 = i_piece[1];
    assign h_reg  = sel_w0 ? i_win0_h : i_win1_h;
    assign v_reg  = sel_w0 ? i_win0_v : i_win1_v;
    assign ctl    = sel_w0 ? i_inside[7:0] : i_inside[15:8];
    assign en     = sel_w0 ? i_enables[0] : i_enables[1];

    assign hr = clamp_range(h_reg, LINE_WIDTH);
    assign vr = clamp_range(v_reg, VISIBLE_LINES);

    // Vertical range may wrap past the bottom of the frame.
    assign v_active = (vr.hi >= vr.lo) ? (i_line >= vr.lo && i_line < vr.hi)
                                       : !(i_line >= vr.hi && i_line < vr.lo);
    assign wrap = (hr.hi < hr.lo);

    always_comb begin
        if (!i_piece[0]) begin
            start   = wrap ? 8'd0 : hr.lo;
            seg_end = hr.hi;
            has     = 1'b1;
        end else begin
            start   = hr.lo;
            seg_end = LINE_WIDTH;
            has     = wrap;
        end
    end

    assign o_piece.valid   = en && v_active && has && (seg_end != 8'd0);
    assign o_piece.start   = start;
    assign o_piece.seg_end = seg_end;
    assign o_piece.ctl     = ctl;

endmodule
`default_nettype wire

// ===== hdl/scanline_window_span_builder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Output: segments leave one per cycle while i_m_axis_tready is high; a new line is
//   accepted only once every segment of the previous line has been issued.
// Reset (i_rst_n low, synchronous): configuration registers to zero, sequencer idle, output
//   empty; the segment cells are not cleared.
// ============================================================================
// scanline_window_span_builder
// Builds the ordered window segment list for one scanline and streams it out.
// ============================================================================
module scanline_window_span_builder #(
    parameter int MAX_SEGMENTS = swsb_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [swsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swsb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // line input
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // [7:0] line
    // segment output
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [15:0]                     o_m_axis_tdata,  // [7:0] segment_end,
                                                             // [15:8] segment_control
    output logic                            o_m_axis_tlast   // last_segment
);
    import swsb_pkg::*;

    localparam int               IW    = $clog2(MAX_SEGMENTS);
    localparam int               GE_N  = 2 ** IW;
    localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_SEGMENTS);
    localparam logic [POS_W-1:0] TOP_P = POS_W'(MAX_SEGMENTS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_win0_h, r_win1_h, r_win0_v, r_win1_v, r_inside;
    logic [7:0]  r_outside;
    logic [2:0]  r_enables;
    logic        cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0_h  <= '0;
            r_win1_h  <= '0;
            r_win0_v  <= '0;
            r_win1_v  <= '0;
            r_inside  <= '0;
            r_outside <= '0;
            r_enables <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_WIN0_H:  r_win0_h  <= i_cfg_data;
                CFG_WIN1_H:  r_win1_h  <= i_cfg_data;
                CFG_WIN0_V:  r_win0_v  <= i_cfg_data;
                CFG_WIN1_V:  r_win1_v  <= i_cfg_data;
                CFG_INSIDE:  r_inside  <= i_cfg_data;
                CFG_OUTSIDE: r_outside <= i_cfg_data[7:0];
                CFG_ENABLES: r_enables <= i_cfg_data[2:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [7:0]       r_line, n_line;
    logic [2:0]       r_piece, n_piece;
    logic [7:0]       r_start, n_start;
    logic [7:0]       r_end, n_end;
    logic [7:0]       r_ctl, n_ctl;
    logic [7:0]       r_old_end, n_old_end;
    logic [7:0]       r_old_ctl, n_old_ctl;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_remain, n_remain;

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_end, n_out_end;
    logic [7:0]       r_out_ctl, n_out_ctl;
    logic             r_out_last, n_out_last;

    t_cell_cmd        cmd;
    t_piece           piece;

    // ------------------------------------------------------------------
    // Piece generator: clamping, vertical test and wrap split
    // ------------------------------------------------------------------
    swsb_piece_gen u_piece_gen (
        .i_win0_h  (r_win0_h),
        .i_win1_h  (r_win1_h),
        .i_win0_v  (r_win0_v),
        .i_win1_v  (r_win1_v),
        .i_inside  (r_inside),
        .i_enables (r_enables[1:0]),
        .i_line    (r_line),
        .i_piece   (r_piece[1:0]),
        .o_piece   (piece)
    );

    // ------------------------------------------------------------------
    // Cell row. Entry i lives in cell i; neighbors trade entries for
    // inserts (move up), trims and the output drain (move down).
    // ------------------------------------------------------------------
    logic [7:0]          w_end  [MAX_SEGMENTS];
    logic [7:0]          w_ctl  [MAX_SEGMENTS];
    t_cell_stat          w_stat [MAX_SEGMENTS];
    logic [MAX_SEGMENTS:0] w_seen;
    logic [MAX_SEGMENTS-1:0] w_first;
    logic [GE_N-1:0]     w_ge;

    assign w_seen[0] = 1'b0;

    for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
        logic [7:0] prev_end, prev_ctl, next_end, next_ctl;

        if (i == 0) begin : g_head
            assign prev_end = 8'd0;
            assign prev_ctl = 8'd0;
        end else begin : g_body
            assign prev_end = w_end[i-1];
            assign prev_ctl = w_ctl[i-1];
        end

        if (i == MAX_SEGMENTS - 1) begin : g_tail
            assign next_end = 8'd0;
            assign next_ctl = 8'd0;
        end else begin : g_link
            assign next_end = w_end[i+1];
            assign next_ctl = w_ctl[i+1];
        end

        swsb_cell #(.IDX(i)) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_prev_end (prev_end),
            .i_prev_ctl (prev_ctl),
            .i_next_end (next_end),
            .i_next_ctl (next_ctl),
            .i_seen     (w_seen[i]),
            .o_end      (w_end[i]),
            .o_ctl      (w_ctl[i]),
            .o_seen     (w_seen[i+1]),
            .o_stat     (w_stat[i])
        );

        assign w_first[i] = w_stat[i].first;
        assign w_ge[i]    = w_stat[i].ge;
    end

    for (genvar i = MAX_SEGMENTS; i < GE_N; i++) begin : g_ge_pad
        assign w_ge[i] = 1'b0;
    end

    // Gather the first overlapped entry (one-hot, so an AND-OR mux).
    logic             win_found, win_split;
    logic [POS_W-1:0] win_pos;
    logic [7:0]       win_end, win_ctl;

    assign win_found = w_seen[MAX_SEGMENTS];

    always_comb begin
        win_split = 1'b0;
        win_pos   = '0;
        win_end   = '0;
        win_ctl   = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            win_split = win_split | (w_first[i] & w_stat[i].split);
            win_pos   = win_pos | (w_first[i] ? POS_W'(i) : '0);
            win_end   = win_end | (w_first[i] ? w_end[i] : 8'd0);
            win_ctl   = win_ctl | (w_first[i] ? w_ctl[i] : 8'd0);
        end
    end

    // ------------------------------------------------------------------
    // Next state and cell commands
    // ------------------------------------------------------------------
    logic             in_acc, out_free, trim_go;
    logic [POS_W-1:0] pos_p1, pos_p2, cnt_inc, list_top;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign pos_p1   = r_pos + POS_W'(1);
    assign pos_p2   = r_pos + POS_W'(2);
    // A full list drops its last entry on insert.
    assign cnt_inc  = (r_count < MAX_P) ? (r_count + POS_W'(1)) : r_count;
    assign list_top = (r_count >= MAX_P) ? TOP_P : r_count;
    assign trim_go  = (r_count > pos_p1) && (pos_p1 < MAX_P) && w_ge[r_pos[IW-1:0]];

    always_comb begin
        n_state     = r_state;
        n_line      = r_line;
        n_piece     = r_piece;
        n_start     = r_start;
        n_end       = r_end;
        n_ctl       = r_ctl;
        n_old_end   = r_old_end;
        n_old_ctl   = r_old_ctl;
        n_pos       = r_pos;
        n_count     = r_count;
        n_remain    = r_remain;
        n_out_valid = r_out_valid;
        n_out_end   = r_out_end;
        n_out_ctl   = r_out_ctl;
        n_out_last  = r_out_last;

        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        cmd.op     = CELL_HOLD;
        cmd.pos    = r_pos;
        cmd.top    = list_top;
        cmd.count  = r_count;
        cmd.lo_end = r_start;
        cmd.hi_end = r_end;
        cmd.ctl    = r_ctl;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_line  = i_s_axis_tdata;
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                // Whole line starts as one segment; no windows means all layers on.
                cmd.op  = CELL_INIT;
                cmd.ctl = (r_enables != 3'd0) ? r_outside : NO_WIN_CTL;
                n_count = POS_W'(1);
                n_piece = (r_enables != 3'd0) ? 3'd0 : PIECES_DONE;
                n_state = ST_PREP;
            end
            ST_PREP: begin
                if (r_piece == PIECES_DONE) begin
                    n_remain = (r_count < RESULT_LIMIT) ? r_count : RESULT_LIMIT;
                    n_state  = ST_EMIT;
                end else if (piece.valid) begin
                    n_start = piece.start;
                    n_end   = piece.seg_end;
                    n_ctl   = piece.ctl;
                    n_state = ST_FIND;
                end else begin
                    n_piece = r_piece + 3'd1;
                end
            end
            ST_FIND: begin
                // Cells compare the piece start against their ends.
                if (!win_found) begin
                    n_piece = r_piece + 3'd1;
                    n_state = ST_PREP;
                end else begin
                    n_pos     = win_pos;
                    n_old_end = win_end;
                    n_old_ctl = win_ctl;
                    n_state   = win_split ? ST_SPLIT : ST_WRITE;
                end
            end
            ST_SPLIT: begin
                cmd.op  = CELL_SPLIT;
                n_count = cnt_inc;
                if (pos_p1 >= MAX_P) begin
                    n_piece = r_piece + 3'd1;
                    n_state = ST_PREP;
                end else if (r_end >= r_old_end) begin
                    n_pos   = pos_p2;
                    n_state = ST_TRIM;
                end else if (pos_p2 >= MAX_P) begin
                    n_piece = r_piece + 3'd1;
                    n_state = ST_PREP;
                end else begin
                    n_pos   = pos_p2;
                    n_state = ST_OPEN;
                end
            end
            ST_WRITE: begin
                cmd.op = CELL_WRITE;
                if (r_end >= r_old_end) begin
                    n_pos   = pos_p1;
                    n_state = ST_TRIM;
                end else if (pos_p1 >= MAX_P) begin
                    n_piece = r_piece + 3'd1;
                    n_state = ST_PREP;
                end else begin
                    n_pos   = pos_p1;
                    n_state = ST_OPEN;
                end
            end
            ST_TRIM: begin
                // One covered entry folded per cycle.
                if (trim_go) begin
                    cmd.op  = CELL_TRIM;
                    n_count = r_count - POS_W'(1);
                    n_pos   = pos_p1;
                end else begin
                    n_piece = r_piece + 3'd1;
                    n_state = ST_PREP;
                end
            end
            ST_OPEN: begin
                // Re-insert the remainder of the segment the piece landed in.
                cmd.op     = CELL_OPEN;
                cmd.hi_end = r_old_end;
                cmd.ctl    = r_old_ctl;
                n_count    = cnt_inc;
                n_piece    = r_piece + 3'd1;
                n_state    = ST_PREP;
            end
            ST_EMIT: begin
                // Drain from cell 0, row moves down one entry per transaction.
                if (out_free) begin
                    cmd.op      = CELL_SHIFT;
                    n_out_valid = 1'b1;
                    n_out_end   = w_end[0];
                    n_out_ctl   = w_ctl[0];
                    n_out_last  = (r_remain == POS_W'(1));
                    n_remain    = r_remain - POS_W'(1);
                    if (r_remain == POS_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_piece     <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_piece     <= n_piece;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line     <= n_line;
        r_start    <= n_start;
        r_end      <= n_end;
        r_ctl      <= n_ctl;
        r_old_end  <= n_old_end;
        r_old_ctl  <= n_old_ctl;
        r_out_end  <= n_out_end;
        r_out_ctl  <= n_out_ctl;
        r_out_last <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_ctl, r_out_end};
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_P)
        else $error("segment count above list depth");

    a_first_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIND) |-> $onehot0(w_first))
        else $error("more than one first overlapped entry");

    a_emit_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_remain != '0) && (r_remain <= RESULT_LIMIT))
        else $error("drain count out of range");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && r_remain == POS_W'(1))
            |=> (r_state == ST_IDLE) && o_m_axis_tvalid && o_m_axis_tlast)
        else $error("final segment not marked last");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for scanline_window_span_builder: programs the window
// registers, streams scanline numbers in and checks every segment that comes
// out against a cycle-free software predictor of the window overlay.
// ============================================================================
module tb;
    import swsb_pkg::*;

    // Predictor geometry; the DUT runs with its default list depth.
    localparam int SPAN_SLOTS     = MAX_SEGMENTS_DEF;
    localparam int COLS           = LINE_WIDTH;
    localparam int ROWS           = VISIBLE_LINES;
    localparam int EMIT_LIMIT     = RESULT_LIMIT;
    // Worst case is roughly 400 lines, each built and then drained under heavy
    // sink stall; allow a large margin.
    localparam int TIMEOUT_NS     = 2_000_000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int RAND_SETTINGS  = 4;
    localparam int RAND_LINES     = 22;

    // ------------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_reg              i_cfg_index     = CFG_WIN0_H;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata  = '0;   // [7:0] line
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b1;
    logic [15:0]           o_m_axis_tdata;         // [7:0] segment end, [15:8] control
    logic                  o_m_axis_tlast;         // last segment of the line

    scanline_window_span_builder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow registers and segment list of the predictor
    // ------------------------------------------------------------------------
    logic [15:0] win0_h, win1_h, win0_v, win1_v, inside_ctl;
    logic [7:0]  outside_ctl;
    logic [2:0]  win_en;

    int span_stop [SPAN_SLOTS];
    int span_ctl  [SPAN_SLOTS];
    int span_cnt;

    typedef struct packed {
        logic [7:0] stop;
        logic [7:0] ctl;
        logic       last;
    } t_span;

    // Segments predicted for accepted lines, oldest first.
    t_span pending_spans [$];

    int mismatches       = 0;
    int lines_sent       = 0;
    int spans_checked    = 0;
    int settings_applied = 0;
    int sender_idle_pct  = 0;
    int sink_stall_pct   = 0;

    // Register values are clamped on use: a start past the limit that also
    // lies past the end becomes 0; an end past the limit is pulled back to it,
    // dragging an out-of-range start along.
    function automatic void clamp_range(input logic [15:0] raw, input int lim,
                                        output int lo, output int hi);
        int s, e;
        e = raw[7:0];
        s = raw[15:8];
        if (s > lim && s > e) s = 0;
        if (e > lim) begin
            e = lim;
            if (s > lim) s = lim;
        end
        lo = s;
        hi = e;
    endfunction

    // Push entries at pos and above up by one; a full list drops its tail.
    function automatic void open_slot(input int pos);
        int top;
        top = span_cnt;
        if (top >= SPAN_SLOTS) begin
            top = SPAN_SLOTS - 1;
        end else begin
            span_cnt++;
        end
        for (int k = top; k > pos; k--) begin
            span_stop[k] = span_stop[k-1];
            span_ctl[k]  = span_ctl[k-1];
        end
    endfunction

    // Insert / overwrite / trim pass for one piece [start, stop).
    function automatic void place_piece(input int start, input int stop, input int ctl);
        int a, startx, old_stop, old_ctl;
        startx = 0;
        if (stop == 0) return;   // empty piece leaves the list alone
        for (a = 0; a < span_cnt && a < SPAN_SLOTS; a++) begin
            if (start < span_stop[a]) begin
                old_stop = span_stop[a];
                old_ctl  = span_ctl[a];
                if (start > startx) begin
                    open_slot(a);
                    span_stop[a] = start;
                    a++;
                    if (a >= SPAN_SLOTS) return;
                end
                span_ctl[a]  = ctl;
                span_stop[a] = stop;
                if (stop >= old_stop) begin
                    // trim: pull one follower down per covered entry
                    a++;
                    while (span_cnt > a + 1 && a + 1 < SPAN_SLOTS && stop >= span_stop[a]) begin
                        span_stop[a] = span_stop[a+1];
                        span_ctl[a]  = span_ctl[a+1];
                        span_cnt--;
                        a++;
                    end
                end else begin
                    // piece ends inside the old segment: restore its tail
                    a++;
                    if (a >= SPAN_SLOTS) return;
                    open_slot(a);
                    span_stop[a] = old_stop;
                    span_ctl[a]  = old_ctl;
                end
                return;
            end
            startx = span_stop[a];
        end
    endfunction

    function automatic void overlay_window(input logic [15:0] hraw, input logic [15:0] vraw,
                                           input logic [7:0] ctl, input int line);
        int hs, he, vs, ve;
        clamp_range(vraw, ROWS, vs, ve);
        if (ve >= vs) begin
            if (line >= ve || line < vs) return;
        end else if (line >= ve && line < vs) begin
            return;   // wrapped vertical range: the gap is outside
        end
        clamp_range(hraw, COLS, hs, he);
        if (he > COLS || he < hs) begin
            // wrapped horizontal range is laid down as two pieces
            place_piece(0, he, ctl);
            place_piece(hs, COLS, ctl);
        end else begin
            place_piece(hs, he, ctl);
        end
    endfunction

    // Build the segment list for one line and queue its segments.
    function automatic void predict_line(input logic [7:0] line);
        int n;
        span_stop[0] = COLS;
        span_cnt     = 1;
        if (win_en != 3'd0) begin
            span_ctl[0] = outside_ctl;
            if (win_en[1]) overlay_window(win1_h, win1_v, inside_ctl[15:8], line);
            if (win_en[0]) overlay_window(win0_h, win0_v, inside_ctl[7:0], line);
        end else begin
            span_ctl[0] = NO_WIN_CTL;
        end
        n = span_cnt;
        if (n > SPAN_SLOTS) n = SPAN_SLOTS;
        if (n > EMIT_LIMIT) n = EMIT_LIMIT;
        for (int k = 0; k < n; k++) begin
            pending_spans.push_back(t_span'{stop: 8'(span_stop[k]), ctl: 8'(span_ctl[k]),
                                            last: (k == n - 1)});
        end
    endfunction

    // ------------------------------------------------------------------------
    // Segment checker and output back-pressure
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_spans.size() == 0) begin
                $display("%0t: unexpected segment end=%0d ctl=%0h last=%0b", $time,
                         o_m_axis_tdata[7:0], o_m_axis_tdata[15:8], o_m_axis_tlast);
                mismatches++;
            end else begin
                want = pending_spans.pop_front();
                spans_checked++;
                if (o_m_axis_tdata[7:0] !== want.stop) begin
                    $display("%0t: segment end expected %0d got %0d", $time,
                             want.stop, o_m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (o_m_axis_tdata[15:8] !== want.ctl) begin
                    $display("%0t: segment control expected %0h got %0h", $time,
                             want.ctl, o_m_axis_tdata[15:8]);
                    mismatches++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $display("%0t: segment last expected %0b got %0b", $time,
                             want.last, o_m_axis_tlast);
                    mismatches++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Stop sending and let every queued segment drain; the block is idle after.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_spans.size() != 0);
    endtask

    // One register write transaction; valid is left high for the caller.
    task automatic write_reg(input t_cfg_reg idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WIN0_H:  win0_h      = value;
            CFG_WIN1_H:  win1_h      = value;
            CFG_WIN0_V:  win0_v      = value;
            CFG_WIN1_V:  win1_v      = value;
            CFG_INSIDE:  inside_ctl  = value;
            CFG_OUTSIDE: outside_ctl = value[7:0];
            CFG_ENABLES: win_en      = value[2:0];
            default: ;
        endcase
    endtask

    // Full register set, written only once the block has gone idle.
    task automatic load_regs(input logic [15:0] h0, input logic [15:0] h1,
                             input logic [15:0] v0, input logic [15:0] v1,
                             input logic [15:0] ctl_in, input logic [7:0] ctl_out,
                             input logic [2:0] en);
        wait_drained();
        write_reg(CFG_WIN0_H,  h0);
        write_reg(CFG_WIN1_H,  h1);
        write_reg(CFG_WIN0_V,  v0);
        write_reg(CFG_WIN1_V,  v1);
        write_reg(CFG_INSIDE,  ctl_in);
        write_reg(CFG_OUTSIDE, {8'd0, ctl_out});
        write_reg(CFG_ENABLES, {13'd0, en});
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // One line transaction, preceded by a random idle gap.
    task automatic send_line(input logic [7:0] line);
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= line;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_line(line);
        lines_sent++;
    endtask

    // Mostly in-range coordinate, sometimes anything the byte can hold.
    function automatic logic [7:0] pick_coord(input int lim);
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, lim));
    endfunction

    function automatic logic [15:0] rand_span(input int lim);
        logic [7:0] s, e;
        s = pick_coord(lim);
        e = pick_coord(lim);
        return {s, e};
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Registers at reset: no window enabled, a single full-width segment.
    task automatic test_reset_defaults();
        send_line(8'd0);
        send_line(8'd255);
    endtask

    // Object window alone: list stays one outside-control segment.
    task automatic test_object_window_only();
        load_regs(16'h1020, 16'h3040, 16'h0050, 16'h0050, 16'hBEEF, 8'hA5, 3'b100);
        send_line(8'd7);
    endtask

    // Two plain windows overlapping; lines on and off each vertical range.
    task automatic test_overlap();
        load_regs({8'd40, 8'd120}, {8'd80, 8'd200}, {8'd0, 8'd160}, {8'd10, 8'd100},
                  16'h3CC3, 8'h11, 3'b011);
        send_line(8'd0);
        send_line(8'd5);
        send_line(8'd50);
        send_line(8'd159);
        send_line(8'd160);
        send_line(8'd255);
    endtask

    // Horizontal wrap, vertical wrap and the clamping of far-out registers.
    task automatic test_wraps();
        load_regs({8'd200, 8'd30}, {8'd250, 8'd10}, {8'd150, 8'd20}, {8'd255, 8'd200},
                  16'h5AA5, 8'h0F, 3'b111);
        send_line(8'd10);
        send_line(8'd30);
        send_line(8'd100);
        send_line(8'd155);
        send_line(8'd255);
    endtask

    // Zero-width pieces, one of them clamped to the right edge.
    task automatic test_zero_width();
        load_regs({8'd100, 8'd100}, {8'd255, 8'd255}, {8'd0, 8'd255}, {8'd0, 8'd255},
                  16'hFFFF, 8'h00, 3'b011);
        send_line(8'd0);
        send_line(8'd80);
        send_line(8'd159);
    endtask

    // Empty window 0 over a full-width window 1.
    task automatic test_empty_and_full();
        load_regs({8'd0, 8'd0}, {8'd0, 8'd240}, {8'd0, 8'd160}, {8'd0, 8'd160},
                  16'h7E81, 8'hC3, 3'b011);
        send_line(8'd1);
        send_line(8'd100);
        send_line(8'd200);
    endtask

    // Every register at its top value, then everything zero with windows on.
    task automatic test_extreme_regs();
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 3'b111);
        send_line(8'd128);
        load_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'b111);
        send_line(8'd64);
    endtask

    // Random settings and lines under one idling profile. With hold_midway the
    // sender stops halfway until all queued segments are out.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input bit hold_midway);
        logic [7:0] line;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        for (int s = 0; s < RAND_SETTINGS; s++) begin
            case ($urandom_range(0, 7))
                0: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 3'b111);
                1: load_regs(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                             16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                             16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                             3'($urandom_range(0, 7)));
                default: load_regs(rand_span(COLS), rand_span(COLS), rand_span(ROWS),
                                   rand_span(ROWS), 16'($urandom_range(0, 16'hFFFF)),
                                   8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
            endcase
            for (int i = 0; i < RAND_LINES; i++) begin
                if (hold_midway && s == RAND_SETTINGS / 2 && i == RAND_LINES / 2)
                    wait_drained();
                line = $urandom_range(0, 1) ? 8'($urandom_range(0, ROWS - 1))
                                            : 8'($urandom_range(0, 255));
                send_line(line);
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        // shadow copy starts at the reset values
        win0_h      = '0;
        win1_h      = '0;
        win0_v      = '0;
        win1_v      = '0;
        inside_ctl  = '0;
        outside_ctl = '0;
        win_en      = '0;
        span_cnt    = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_object_window_only();
        test_overlap();
        test_wraps();
        test_zero_width();
        test_empty_and_full();
        test_extreme_regs();

        test_random_traffic(0, 0, 1'b1);
        test_random_traffic(67, 0, 1'b0);
        test_random_traffic(0, 67, 1'b0);
        test_random_traffic(6, 6, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d lines over %0d register settings, %0d segments checked",
                 lines_sent, settings_applied, spans_checked);
        $display("idle profiles: none, sender gaps, sink stalls, light mix; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("scanline_window_span_builder regression: pass");
        end else begin
            $display("scanline_window_span_builder regression: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d segments still expected", pending_spans.size());
        $display("scanline_window_span_builder regression: fail");
        $finish;
    end

endmodule

// ===== scanline_window_span_builder.f =====
hdl/swsb_pkg.sv
hdl/swsb_cell.sv
hdl/swsb_piece_gen.sv
hdl/scanline_window_span_builder.sv
bench/tb.sv
